FILE: src/char_frequency_rank_core_defines.svh
// Assertion macros for the character frequency rank block.
// Taken in by the top level; it depends on clk_i and rst_ni there.
`ifndef CHAR_FREQUENCY_RANK_CORE_DEFINES_SVH
`define CHAR_FREQUENCY_RANK_CORE_DEFINES_SVH

`ifndef SYNTH
`define CFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFR_ASSERT_IMPL(lbl, ante, cons, msg)
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/cfr_pkg.sv
// Shared constants, state encoding and control struct of the character
// frequency rank block. No dependencies.
package cfr_pkg;

  localparam int unsigned FIRST_CODE      = 33;
  localparam int unsigned END_CODE        = 127;
  localparam int unsigned NUM_SYMBOLS_DEF = END_CODE - FIRST_CODE;
  localparam int unsigned COUNT_BITS_DEF  = 24;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned RANK_W  = 7;
  localparam int unsigned CODE_W  = 7;
  localparam int unsigned SCOUNT_W = 24;

  localparam logic [CMD_W-1:0] CMD_COUNT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_RK_LOAD,
    ST_RK_HOLD,
    ST_RK_SCAN,
    ST_REPORT
  } cfr_state_e;

  typedef struct packed {
    logic wr_en;
    logic clear_all;
  } cfr_mem_ctl_t;

endpackage

FILE: src/cfr_if.sv
// Channel interfaces of the character frequency rank block: input items,
// result items and the rank register write. Depends on cfr_pkg.
interface cfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [cfr_pkg::CMD_W-1:0]   command;
  logic [cfr_pkg::DATA_W-1:0]  data_byte;
  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface cfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [cfr_pkg::CODE_W-1:0]    symbol_code;
  logic [cfr_pkg::SCOUNT_W-1:0]  symbol_count;
  modport source (output valid, output symbol_code, output symbol_count, input ready);
  modport sink (input valid, input symbol_code, input symbol_count, output ready);
endinterface

interface cfr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cfr_pkg::RANK_W-1:0]  rank_wanted;
  modport source (output valid, output rank_wanted, input ready);
  modport sink (input valid, input rank_wanted, output ready);
endinterface

FILE: src/cfr_count_mem.sv
// Histogram storage: one counter per symbol with a registered read port and
// per-entry valid bits, so the whole table clears at once. Uses cfr_pkg.
module cfr_count_mem #(
  parameter int unsigned NUM_SYMBOLS = cfr_pkg::NUM_SYMBOLS_DEF,
  parameter int unsigned COUNT_BITS  = cfr_pkg::COUNT_BITS_DEF,
  localparam int unsigned IDX_W      = $clog2(NUM_SYMBOLS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfr_pkg::cfr_mem_ctl_t ctl_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  logic [COUNT_BITS-1:0] wdata_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output logic [COUNT_BITS-1:0] rdata_o
);

  logic [COUNT_BITS-1:0]  mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld_q;
  logic [COUNT_BITS-1:0]  rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // An entry that has not been written since the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clear_all) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: src/char_frequency_rank_core.sv
// Character frequency rank core, built on cfr_pkg, cfr_if and cfr_count_mem.
// A count transaction of a symbol goes through accept, read, then write back of a
// saturating increment; a byte outside the symbol range is only accepted. A finish
// tests candidates in code order, one at a time on the single comparator. Reset
// empties the histogram at once and sets the rank to 1.
module char_frequency_rank_core #(
  parameter int unsigned NUM_SYMBOLS = cfr_pkg::NUM_SYMBOLS_DEF,
  parameter int unsigned COUNT_BITS  = cfr_pkg::COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfr_in_if.sink       in_i,
  cfr_out_if.source    out_o,
  cfr_cfg_if.sink      cfg_i
);

  `include "char_frequency_rank_core_defines.svh"

  localparam int unsigned IDX_W = $clog2(NUM_SYMBOLS);
  localparam int unsigned TW    = $clog2(NUM_SYMBOLS + 1);
  localparam int unsigned RW    = (TW > cfr_pkg::RANK_W) ? TW : cfr_pkg::RANK_W;

  cfr_pkg::cfr_state_e state_q, state_d;

  logic [cfr_pkg::RANK_W-1:0] rank_q;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [IDX_W-1:0]           s_q, s_d;
  logic [TW-1:0]              t_q, t_d;
  logic [IDX_W-1:0]           tag_q, tag_d;
  logic                       data_ok_q, data_ok_d;
  logic [TW-1:0]              before_q, before_d;
  logic [COUNT_BITS-1:0]      key_cnt_q, key_cnt_d;

  logic                          out_valid_q;
  logic [cfr_pkg::CODE_W-1:0]    out_code_q, out_code_d;
  logic [cfr_pkg::SCOUNT_W-1:0]  out_count_q, out_count_d;
  logic                          out_load;

  cfr_pkg::cfr_mem_ctl_t  mem_ctl;
  logic [IDX_W-1:0]       raddr;
  logic [COUNT_BITS-1:0]  rdata;
  logic [COUNT_BITS-1:0]  wdata;

  logic                   in_fire;
  logic [8:0]             byte_off;
  logic                   in_range;
  logic [RW-1:0]          rank_ext;
  logic [RW-1:0]          rank_clamped;
  logic [TW-1:0]          target;
  logic                   ahead;
  logic                   scan_done;
  logic [15:0]            code_sum;

  cfr_count_mem #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mem_ctl),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready  = (state_q == cfr_pkg::ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign byte_off = {1'b0, in_i.data_byte} - 9'(cfr_pkg::FIRST_CODE);
  assign in_range = (in_i.data_byte >= 8'(cfr_pkg::FIRST_CODE))
                 && (byte_off < 9'(NUM_SYMBOLS));

  // Rank zero acts as rank one; ranks past the table act as the last rank.
  assign rank_ext = RW'(rank_q);
  always_comb begin
    if (rank_ext == '0) begin
      rank_clamped = RW'(1);
    end else if (rank_ext > RW'(NUM_SYMBOLS)) begin
      rank_clamped = RW'(NUM_SYMBOLS);
    end else begin
      rank_clamped = rank_ext;
    end
  end
  assign target = TW'(rank_clamped - RW'(1));

  // Ordering key: higher count first, then lower code first.
  assign ahead     = {rdata, ~tag_q} > {key_cnt_q, ~s_q};
  assign scan_done = (t_q == TW'(NUM_SYMBOLS)) && !data_ok_q;

  assign wdata    = (&rdata) ? rdata : rdata + COUNT_BITS'(1);
  assign code_sum = 16'(s_q) + 16'(cfr_pkg::FIRST_CODE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      cfr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.command == cfr_pkg::CMD_FINISH) begin
            state_d = cfr_pkg::ST_RK_LOAD;
          end else if (in_range) begin
            state_d = cfr_pkg::ST_CNT_RD;
          end
        end
      end
      cfr_pkg::ST_CNT_RD:  state_d = cfr_pkg::ST_CNT_WR;
      cfr_pkg::ST_CNT_WR:  state_d = cfr_pkg::ST_IDLE;
      cfr_pkg::ST_RK_LOAD: state_d = cfr_pkg::ST_RK_HOLD;
      cfr_pkg::ST_RK_HOLD: state_d = cfr_pkg::ST_RK_SCAN;
      cfr_pkg::ST_RK_SCAN: begin
        if (scan_done) begin
          state_d = (before_q == target) ? cfr_pkg::ST_REPORT : cfr_pkg::ST_RK_LOAD;
        end
      end
      cfr_pkg::ST_REPORT: begin
        if (out_load) begin
          state_d = cfr_pkg::ST_IDLE;
        end
      end
      default: state_d = cfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    s_d         = s_q;
    t_d         = t_q;
    tag_d       = tag_q;
    data_ok_d   = 1'b0;
    before_d    = before_q;
    key_cnt_d   = key_cnt_q;
    raddr       = idx_q;
    mem_ctl     = '0;
    out_load    = 1'b0;
    out_code_d  = out_code_q;
    out_count_d = out_count_q;
    case (state_q)
      cfr_pkg::ST_IDLE: begin
        idx_d = byte_off[IDX_W-1:0];
        s_d   = '0;
      end
      cfr_pkg::ST_CNT_RD: begin
        raddr = idx_q;
      end
      cfr_pkg::ST_CNT_WR: begin
        mem_ctl.wr_en = 1'b1;
      end
      cfr_pkg::ST_RK_LOAD: begin
        raddr    = s_q;
        t_d      = '0;
        before_d = '0;
      end
      cfr_pkg::ST_RK_HOLD: begin
        key_cnt_d = rdata;
      end
      cfr_pkg::ST_RK_SCAN: begin
        // Issue one read per cycle; compare the data of the previous read.
        raddr = t_q[IDX_W-1:0];
        if (t_q < TW'(NUM_SYMBOLS)) begin
          tag_d     = t_q[IDX_W-1:0];
          data_ok_d = 1'b1;
          t_d       = t_q + TW'(1);
        end
        if (data_ok_q && ahead) begin
          before_d = before_q + TW'(1);
        end
        if (scan_done && (before_q != target)) begin
          s_d = s_q + IDX_W'(1);
        end
      end
      cfr_pkg::ST_REPORT: begin
        out_load          = !out_valid_q || out_o.ready;
        mem_ctl.clear_all = out_load;
        out_code_d        = code_sum[cfr_pkg::CODE_W-1:0];
        out_count_d       = cfr_pkg::SCOUNT_W'(key_cnt_q);
      end
      default: begin
        raddr = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfr_pkg::ST_IDLE;
      rank_q      <= cfr_pkg::RANK_W'(1);
      data_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      data_ok_q <= data_ok_d;
      if (cfg_i.valid && cfg_i.ready) begin
        rank_q <= cfg_i.rank_wanted;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    s_q       <= s_d;
    t_q       <= t_d;
    tag_q     <= tag_d;
    before_q  <= before_d;
    key_cnt_q <= key_cnt_d;
    if (out_load) begin
      out_code_q  <= out_code_d;
      out_count_q <= out_count_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.symbol_code  = out_code_q;
  assign out_o.symbol_count = out_count_q;

  `CFR_ASSERT_IMPL(a_rose_from_report, $rose(out_valid_q),
                   $past(state_q == cfr_pkg::ST_REPORT),
                   "result appeared outside the report step")
  `CFR_ASSERT_NEXT(a_clear_with_result, mem_ctl.clear_all, out_valid_q,
                   "histogram cleared without a result")
  `CFR_ASSERT_IMPL(a_before_bounded, state_q == cfr_pkg::ST_RK_SCAN,
                   before_q < TW'(NUM_SYMBOLS), "rank counter ran past the table")

endmodule
